// ===== design/dsc_pkg.sv =====
// dsc_pkg: shared constants, types and state encoding for the diffusion
// stencil coefficient block
// no dependencies
package dsc_pkg;

   localparam int IDX_W    = 20;
   localparam int VAL_W    = 32;
   localparam int ALB_W    = 17;
   localparam int ENTRY_W  = 48;
   localparam int NUM_ALB  = 6;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W   = 2 * VAL_W;
   localparam int NUM_W    = PROD_W + 17;
   localparam int DEN_W    = PROD_W + 1;
   localparam int QUOT_W   = 47;
   localparam int DIV_STEPS = QUOT_W;
   localparam int CNT_W    = $clog2(DIV_STEPS + 1);
   localparam int REQ_DATA_W = 200;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 88;

   localparam logic [ALB_W-1:0] ONE_Q = ALB_W'(65536);
   localparam logic [QUOT_W-1:0] SAT_MAX = {QUOT_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_SETUP,
      ST_DIV1,
      ST_DIV2,
      ST_ACC,
      ST_OUT_OFF,
      ST_OUT_DIAG
   } state_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_res_type;

endpackage

// ===== design/diffusion_stencil_coefficients.sv =====
// diffusion_stencil_coefficients: top level, sequencer, albedo registers
// and leak sum; depends on dsc_pkg, dsc_mul and dsc_div
//
// A face transaction occupies the block until any results have been taken,
// so a receiver stall prolongs it: three products on the shared 32x32
// multiplier, one divider start step, then two dependent divisions on the
// shared bit-serial divider (47 quotient bits each, one per cycle, the done
// flag of the first also starting the second), one accumulate step and the
// idle state in which the next face is accepted. A division whose quotient
// overflows or whose divisor is zero finishes without iterating.
// An interior face yields an off-diagonal entry, a face marked last yields
// the diagonal (removal plus leak sum) after it, and the next face is
// accepted once those results have been taken.
module diffusion_stencil_coefficients import dsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cell_index, neighbor_index, cell_diff, cell_width, neighbor_diff,
   // neighbor_width, removal
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // face, at_boundary
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // row_out, col_out, entry_value
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ALB_W-1:0]      csr_data
);

   state_type state_ff, state_in;

   logic [ALB_W-1:0]   alb_ff [NUM_ALB];
   logic [ENTRY_W-1:0] leak_ff, leak_in;

   logic [IDX_W-1:0]   row_ff, col_ff;
   logic               bnd_ff, last_ff;
   logic [VAL_W-1:0]   d_ff, h_ff, dn_ff, hn_ff, rem_ff;
   logic [ALB_W-1:0]   om_ff;
   logic [ALB_W:0]     op_ff;
   logic [PROD_W-1:0]  p0_ff, p1_ff;
   logic [QUOT_W-1:0]  t_ff;
   logic [ENTRY_W-1:0] off_ff, diag_ff;

   logic               accept;
   logic [ALB_W-1:0]   alb_sel;
   logic [ALB_W-1:0]   alb_clamp;

   logic [VAL_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]  product;
   logic               div_start;
   logic [NUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   div_res_type        div_res;

   logic               cap_p0, cap_p1, cap_t, do_acc;

   logic [ENTRY_W:0]   leak_sum;
   logic [ENTRY_W-1:0] leak_sat;
   logic signed [ENTRY_W+1:0] diag_full;
   logic [ENTRY_W-1:0] diag_sat;
   logic signed [ENTRY_W+1:0] diag_hi, diag_lo;

   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign alb_sel   = (req_tuser[2:0] < 3'(NUM_ALB)) ? alb_ff[req_tuser[2:0]] : ONE_Q;
   assign alb_clamp = (alb_sel > ONE_Q) ? ONE_Q : alb_sel;

   dsc_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   dsc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .res   (div_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_MUL0;
         ST_MUL0:     state_in = ST_MUL1;
         ST_MUL1:     state_in = ST_MUL2;
         ST_MUL2:     state_in = ST_SETUP;
         ST_SETUP:    state_in = ST_DIV1;
         ST_DIV1:     if (div_res.done) state_in = ST_DIV2;
         ST_DIV2:     if (div_res.done) state_in = ST_ACC;
         ST_ACC: begin
            if (!bnd_ff)
               state_in = ST_OUT_OFF;
            else if (last_ff)
               state_in = ST_OUT_DIAG;
            else
               state_in = ST_IDLE;
         end
         ST_OUT_OFF:  if (rsp_tready) state_in = last_ff ? ST_OUT_DIAG : ST_IDLE;
         ST_OUT_DIAG: if (rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tdata  = {off_ff, col_ff, row_ff};
      rsp_tlast  = 1'b0;
      mul_a      = d_ff;
      mul_b      = dn_ff;
      div_start  = 1'b0;
      div_num    = {p0_ff, 17'b0};
      div_den    = bnd_ff ? (DEN_W'({p1_ff[PROD_W-3:0], 2'b00}) + DEN_W'(product))
                          : (DEN_W'(p1_ff) + DEN_W'(product));
      cap_p0     = 1'b0;
      cap_p1     = 1'b0;
      cap_t      = 1'b0;
      do_acc     = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_MUL0: begin
            mul_a = d_ff;
            mul_b = bnd_ff ? VAL_W'(om_ff) : dn_ff;
         end
         ST_MUL1: begin
            mul_a  = bnd_ff ? d_ff : hn_ff;
            mul_b  = bnd_ff ? VAL_W'(op_ff) : d_ff;
            cap_p0 = 1'b1;
         end
         ST_MUL2: begin
            mul_a  = bnd_ff ? VAL_W'(om_ff) : h_ff;
            mul_b  = bnd_ff ? h_ff : dn_ff;
            cap_p1 = 1'b1;
         end
         ST_SETUP: div_start = 1'b1;
         ST_DIV1: begin
            div_num   = {18'b0, div_res.quot, 16'b0};
            div_den   = DEN_W'(h_ff);
            div_start = div_res.done;
         end
         ST_DIV2: cap_t = div_res.done;
         ST_ACC:  do_acc = 1'b1;
         ST_OUT_OFF: rsp_tvalid = 1'b1;
         ST_OUT_DIAG: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = {diag_ff, row_ff, row_ff};
            rsp_tlast  = 1'b1;
         end
         default: ;
      endcase
   end

   // leak sum and diagonal with saturation
   assign leak_sum  = {1'b0, leak_ff} + (ENTRY_W+1)'(t_ff);
   assign leak_sat  = (leak_sum > (ENTRY_W+1)'(SAT_MAX)) ? ENTRY_W'(SAT_MAX)
                                                        : leak_sum[ENTRY_W-1:0];
   assign diag_full = (ENTRY_W+2)'($signed(rem_ff)) + $signed({2'b00, leak_sat});
   assign diag_hi   = $signed({3'b000, SAT_MAX});
   assign diag_lo   = -diag_hi - $signed((ENTRY_W+2)'(1));
   assign diag_sat  = (diag_full > diag_hi) ? diag_hi[ENTRY_W-1:0]
                    : (diag_full < diag_lo) ? diag_lo[ENTRY_W-1:0]
                    : diag_full[ENTRY_W-1:0];

   always_comb begin
      leak_in = leak_ff;
      if (do_acc)
         leak_in = last_ff ? '0 : leak_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         leak_ff  <= '0;
         for (int i = 0; i < NUM_ALB; i++)
            alb_ff[i] <= ONE_Q;
      end else begin
         state_ff <= state_in;
         leak_ff  <= leak_in;
         if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(NUM_ALB)))
            alb_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff  <= req_tdata[19:0];
         col_ff  <= req_tdata[39:20];
         d_ff    <= req_tdata[71:40];
         h_ff    <= req_tdata[103:72];
         dn_ff   <= req_tdata[135:104];
         hn_ff   <= req_tdata[167:136];
         rem_ff  <= req_tdata[199:168];
         bnd_ff  <= req_tuser[3];
         last_ff <= req_tlast;
         om_ff   <= ONE_Q - alb_clamp;
         op_ff   <= {1'b0, ONE_Q} + {1'b0, alb_clamp};
      end
      if (cap_p0)
         p0_ff <= product;
      if (cap_p1)
         p1_ff <= product;
      if (cap_t)
         t_ff <= div_res.quot;
      if (do_acc) begin
         off_ff  <= '0 - ENTRY_W'(t_ff);
         diag_ff <= diag_sat;
      end
   end

endmodule

// ===== design/dsc_mul.sv =====
// dsc_mul: shared 32x32 unsigned multiplier with registered product
// depends on dsc_pkg
module dsc_mul import dsc_pkg::*; (
   input  logic              clock,
   input  logic [VAL_W-1:0]  op_a,
   input  logic [VAL_W-1:0]  op_b,
   output logic [PROD_W-1:0] product
);

   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== design/dsc_div.sv =====
// dsc_div: iterative restoring divider, one quotient bit per cycle,
// quotient saturated to 47 bits; depends on dsc_pkg
module dsc_div import dsc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output div_res_type      res
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] low_ff, low_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    shifted;
   logic [DEN_W:0]    diff;
   logic              ge;
   logic [DEN_W-1:0]  num_hi;

   assign num_hi  = DEN_W'(num[NUM_W-1:QUOT_W]);
   assign shifted = {rem_ff, low_ff[QUOT_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      if (start) begin
         if (den == '0) begin
            quot_in = (num != '0) ? SAT_MAX : '0;
            done_in = 1'b1;
         end else if (num_hi >= den) begin
            quot_in = SAT_MAX;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            rem_in  = num_hi;
            low_in  = num[QUOT_W-1:0];
            cnt_in  = CNT_W'(DIV_STEPS);
            quot_in = '0;
            den_in  = den;
         end
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         low_in  = {low_ff[QUOT_W-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;

endmodule

// ===== test/dsc_checker.sv =====
// dsc_checker: watches the request, response and csr channels of the
// diffusion stencil coefficient block, predicts each entry and compares
// depends on dsc_pkg for field widths
module dsc_checker import dsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ALB_W-1:0]      csr_data,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic [ENTRY_W-1:0] entry;
      logic               diag;
   } entry_type;

   localparam logic [63:0] SAT48 = 64'h7FFF_FFFF_FFFF;
   localparam logic [63:0] ONE64 = 64'd65536;

   entry_type         entries_due[$];
   logic [ALB_W-1:0]  albedo[NUM_ALB];
   logic [63:0]       leak_sum;

   assign pending = entries_due.size();

   function automatic logic [63:0] sat_quot(logic [127:0] num, logic [127:0] den);
      logic [127:0] q;
      if (den == 0)
         return (num == 0) ? 64'd0 : SAT48;
      q = num / den;
      return (q > SAT48) ? SAT48 : q[63:0];
   endfunction

   function automatic void predict_face(logic [REQ_DATA_W-1:0] d, logic [REQ_USER_W-1:0] u,
                                        logic last);
      logic [IDX_W-1:0] row, col;
      logic [2:0]       face;
      logic             bnd;
      logic [63:0]      cd, cw, nd, nw, a, om, op, dtilde, t;
      logic [127:0]     num, den;
      logic signed [63:0] diag;
      entry_type        e;
      row  = d[19:0];
      col  = d[39:20];
      cd   = d[71:40];
      cw   = d[103:72];
      nd   = d[135:104];
      nw   = d[167:136];
      face = u[2:0];
      bnd  = u[3];
      if (bnd) begin
         a = (face < NUM_ALB) ? 64'(albedo[face]) : ONE64;
         if (a > ONE64)
            a = ONE64;
         om = ONE64 - a;
         op = ONE64 + a;
         num = 128'(cd * om) << 17;
         den = 128'(4 * cd * op + om * cw);
      end else begin
         num = 128'(cd * nd) << 17;
         den = 128'(nw * cd) + 128'(cw * nd);
      end
      dtilde = sat_quot(num, den);
      if (cw == 0)
         t = (dtilde != 0) ? SAT48 : 64'd0;
      else begin
         t = (dtilde << 16) / cw;
         if (t > SAT48)
            t = SAT48;
      end
      leak_sum = leak_sum + t;
      if (leak_sum > SAT48)
         leak_sum = SAT48;
      if (!bnd) begin
         e.row = row;
         e.col = col;
         e.entry = ENTRY_W'(64'd0 - t);
         e.diag = 1'b0;
         entries_due.push_back(e);
      end
      if (last) begin
         diag = 64'(signed'(d[199:168])) + signed'(leak_sum);
         if (diag > signed'(SAT48))
            diag = signed'(SAT48);
         if (diag < -signed'(SAT48) - 1)
            diag = -signed'(SAT48) - 1;
         e.row = row;
         e.col = row;
         e.entry = diag[ENTRY_W-1:0];
         e.diag = 1'b1;
         entries_due.push_back(e);
         leak_sum = 0;
      end
   endfunction

   always @(posedge clock) begin
      entry_type want;
      if (reset) begin
         for (int i = 0; i < NUM_ALB; i++)
            albedo[i] = ONE_Q;
         leak_sum = 0;
         entries_due.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready && csr_index < NUM_ALB)
            albedo[csr_index] = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (entries_due.size() == 0) begin
               $error("unexpected response transaction %h", rsp_tdata);
               fail_count++;
            end else begin
               want = entries_due.pop_front();
               if (rsp_tdata[19:0] !== want.row) begin
                  $error("row_out: expected %0d, got %0d", want.row, rsp_tdata[19:0]);
                  fail_count++;
               end
               if (rsp_tdata[39:20] !== want.col) begin
                  $error("col_out: expected %0d, got %0d", want.col, rsp_tdata[39:20]);
                  fail_count++;
               end
               if (rsp_tdata[87:40] !== want.entry) begin
                  $error("entry_value: expected %h, got %h", want.entry, rsp_tdata[87:40]);
                  fail_count++;
               end
               if (rsp_tlast !== want.diag) begin
                  $error("is_diagonal: expected %b, got %b", want.diag, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_face(req_tdata, req_tuser, req_tlast);
      end
   end

endmodule

// ===== test/tb_diffusion_stencil_coefficients.sv =====
// tb_diffusion_stencil_coefficients: clock, reset and face transaction
// stimulus for the diffusion stencil coefficient block, verdict from dsc_checker
// depends on dsc_pkg, diffusion_stencil_coefficients and dsc_checker
module tb_diffusion_stencil_coefficients;
   import dsc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN = 200;
   localparam int CYCLE_LIMIT = 2000000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid, req_tready, req_tlast;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid, rsp_tready, rsp_tlast;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [ALB_W-1:0]      csr_data;
   int                    fail_count, pending;
   int                    cycles;
   int                    burst_left;
   bit                    hold_go;

   diffusion_stencil_coefficients DUT (.*);
   dsc_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // receiver: random ready runs, plus one long hold-off on request
   initial begin
      int run;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         if (hold_go) begin
            hold_go = 0;
            rsp_tready <= 0;
            repeat (800) @(posedge clock);
         end
         run = $urandom_range(1, 40);
         rsp_tready <= 1;
         repeat (run) @(posedge clock);
         run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (run > 0) begin
            rsp_tready <= 0;
            repeat (run) @(posedge clock);
         end
      end
   end

   task automatic send_face(logic [19:0] row, logic [19:0] col, logic [2:0] face, logic bnd,
                            logic [31:0] cd, logic [31:0] cw, logic [31:0] nd,
                            logic [31:0] nw, logic [31:0] removal, logic last);
      if (burst_left == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata  <= {removal, nw, nd, cw, cd, col, row};
      req_tuser  <= {bnd, face};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_albedo(logic [CSR_IDX_W-1:0] idx, logic [ALB_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value(bit nonzero);
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom();
         1: v = $urandom_range(1, 32'h0004_0000);
         2: v = 32'h0001_0000 + $urandom_range(0, 32'h0000_FFFF);
         3: v = $urandom_range(0, 255);
         default: v = ~($urandom_range(0, 255));
      endcase
      if (nonzero && v == 0)
         v = 1;
      return v;
   endfunction

   task automatic random_cell(output int nsent);
      logic [19:0] row;
      int nfaces;
      bit noise;
      row = 20'($urandom());
      nfaces = $urandom_range(1, 6);
      noise = ($urandom_range(0, 9) == 0);
      for (int f = 0; f < nfaces; f++)
         send_face(row, 20'($urandom()),
                   noise ? 3'($urandom_range(0, 7)) : 3'(f),
                   $urandom_range(0, 2) == 0,
                   pick_value(1), pick_value(1), pick_value(0), pick_value(0),
                   $urandom(), noise ? 1'($urandom_range(0, 1)) : (f == nfaces - 1));
      nsent = nfaces;
   endtask

   task automatic set_albedos(int mode);
      for (int i = 0; i < NUM_ALB; i++)
         case (mode)
            0: write_albedo(CSR_IDX_W'(i), ALB_W'(0));
            1: write_albedo(CSR_IDX_W'(i), 17'h1FFFF);
            2: write_albedo(CSR_IDX_W'(i),
                            ($urandom_range(0, 1) == 0) ? ALB_W'($urandom_range(0, 65536))
                                                        : ALB_W'($urandom()));
            default: write_albedo(CSR_IDX_W'(i), ONE_Q);
         endcase
      csr_valid <= 0;
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 0;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      burst_left = 0;
      hold_go = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reflective defaults, every face selector, extremes
      for (int f = 0; f < 8; f++)
         send_face(20'h0, 20'hFFFFF, 3'(f), 1, 32'hFFFF_FFFF, 32'h1, 0, 0, 32'h7FFF_FFFF,
                   f == 7);
      send_face(20'hFFFFF, 20'h0, 0, 0, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 0, 0, 0);
      send_face(20'hFFFFF, 20'hFFFFF, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'h7FFF_FFFF, 1);
      send_face(20'h12345, 20'h54321, 2, 0, 32'h1, 32'h1, 0, 0, 32'h8000_0000, 1);
      send_face(20'h1, 20'h2, 3, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 32'hFFFF_FFFF, 1);
      send_face(20'h3, 20'h4, 4, 0, 32'h1, 32'h1, 32'h1, 32'h1, 32'h8000_0000, 1);
      settle();

      set_albedos(0);
      for (int f = 0; f < 8; f++)
         send_face(20'h5, 20'h6, 3'(f), 1, 32'h0001_0000, 32'h0002_0000, 0, 0,
                   32'hFFFF_0000, f == 7);
      send_face(20'h7, 20'h8, 0, 1, 32'hFFFF_FFFF, 32'h1, 0, 0, 0, 1);
      settle();

      for (int phase = 0; phase < 5; phase++) begin
         set_albedos(phase == 0 ? 1 : (phase == 4 ? 3 : 2));
         if (phase == 2)
            hold_go = 1;
         for (int n = 0; n < 330; ) begin
            int sent;
            random_cell(sent);
            n += sent;
         end
         settle();
      end

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
